// ===== sv/ps2mpc_pkg.sv =====
// Shared types, constants and codes for the PS/2 mouse packet cursor block.
package ps2mpc_pkg;

    // Width of a cursor coordinate and of a limit register.
    localparam int COORD_BITS = 12;
    // Width of the sign-extended sum used for the clamp.
    localparam int SUM_BITS   = COORD_BITS + 2;

    typedef logic [COORD_BITS-1:0] coord_t;

    // Limit values after reset.
    localparam coord_t LIMIT_X_RESET = COORD_BITS'(1023);
    localparam coord_t LIMIT_Y_RESET = COORD_BITS'(767);

    // Bit positions inside the packet header byte.
    localparam int HDR_LEFT_BIT  = 0;
    localparam int HDR_RIGHT_BIT = 1;
    localparam int HDR_SYNC_BIT  = 3;
    localparam int HDR_XOVF_BIT  = 6;
    localparam int HDR_YOVF_BIT  = 7;

    // Item kinds.
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LIMIT_X = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LIMIT_Y = 1'b1;

    // Position of the next byte inside a three-byte packet.
    typedef enum logic [2:0] {
        POS_HEADER = 3'b001,
        POS_DX     = 3'b010,
        POS_DY     = 3'b100
    } pos_t;

    // One input beat.
    typedef struct packed {
        logic       kind;
        logic [7:0] byte_value;
    } item_t;

    // One result beat.
    typedef struct packed {
        coord_t cursor_x;
        coord_t cursor_y;
        logic   moved_flag;
        logic   left_click;
        logic   left_level;
        logic   right_level;
        logic   packet_done;
    } result_t;

    // Decoder state carried from item to item.
    typedef struct packed {
        pos_t       pos;
        logic [7:0] header;
        logic [7:0] delta_x;
        coord_t     pos_x;
        coord_t     pos_y;
        logic       moved;
        logic       click;
        logic       left;
        logic       right;
    } state_t;

endpackage

// ===== sv/ps2mpc_step.sv =====
// Combinational update of the decoder state and result for one item.
module ps2mpc_step
    import ps2mpc_pkg::*;
(
    input  state_t  cur,
    input  item_t   item,
    input  coord_t  limit_x,
    input  coord_t  limit_y,
    output state_t  nxt,
    output result_t res
);

    logic [7:0]          dx;
    logic [7:0]          dy;
    logic [SUM_BITS-1:0] sum_x;
    logic [SUM_BITS-1:0] sum_y;
    coord_t              new_x;
    coord_t              new_y;
    logic                done;

    // Deltas, forced to zero when the header flags an overflow.
    assign dx = cur.header[HDR_XOVF_BIT] ? 8'd0 : cur.delta_x;
    assign dy = cur.header[HDR_YOVF_BIT] ? 8'd0 : item.byte_value;

    // X moves right with a positive delta, Y moves down with a negative one.
    assign sum_x = {2'b00, cur.pos_x} + {{(SUM_BITS-8){dx[7]}}, dx};
    assign sum_y = {2'b00, cur.pos_y} - {{(SUM_BITS-8){dy[7]}}, dy};

    // Clamp each sum to the range from zero to its limit.
    always_comb
    begin
        if (sum_x[SUM_BITS-1])
        begin
            new_x = '0;
        end
        else if (sum_x[SUM_BITS-2:0] > {1'b0, limit_x})
        begin
            new_x = limit_x;
        end
        else
        begin
            new_x = sum_x[COORD_BITS-1:0];
        end

        if (sum_y[SUM_BITS-1])
        begin
            new_y = '0;
        end
        else if (sum_y[SUM_BITS-2:0] > {1'b0, limit_y})
        begin
            new_y = limit_y;
        end
        else
        begin
            new_y = sum_y[COORD_BITS-1:0];
        end
    end

    // Packet assembly and flag update.
    always_comb
    begin
        nxt  = cur;
        done = 1'b0;
        if (item.kind == KIND_CLEAR)
        begin
            nxt.moved = 1'b0;
            nxt.click = 1'b0;
        end
        else
        begin
            case (cur.pos)
                POS_HEADER:
                begin
                    // A header without the sync bit is dropped.
                    if (item.byte_value[HDR_SYNC_BIT])
                    begin
                        nxt.header = item.byte_value;
                        nxt.pos    = POS_DX;
                    end
                end
                POS_DX:
                begin
                    nxt.delta_x = item.byte_value;
                    nxt.pos     = POS_DY;
                end
                default:
                begin
                    // Final byte: apply the move and the buttons.
                    if ((new_x != cur.pos_x) || (new_y != cur.pos_y))
                    begin
                        nxt.moved = 1'b1;
                    end
                    if (!cur.left && cur.header[HDR_LEFT_BIT])
                    begin
                        nxt.click = 1'b1;
                    end
                    nxt.pos_x = new_x;
                    nxt.pos_y = new_y;
                    nxt.left  = cur.header[HDR_LEFT_BIT];
                    nxt.right = cur.header[HDR_RIGHT_BIT];
                    nxt.pos   = POS_HEADER;
                    done      = 1'b1;
                end
            endcase
        end
    end

    // Every item reports the state it leaves behind.
    always_comb
    begin
        res.cursor_x    = nxt.pos_x;
        res.cursor_y    = nxt.pos_y;
        res.moved_flag  = nxt.moved;
        res.left_click  = nxt.click;
        res.left_level  = nxt.left;
        res.right_level = nxt.right;
        res.packet_done = done;
    end

endmodule

// ===== sv/ps2_mouse_packet_cursor.sv =====
// PS/2 mouse packet decoder with a clamped cursor: top level.
// Each beat on the item channel is either a raw PS/2 mouse byte or a request to
// clear the sticky moved and left-click flags, and each one produces exactly one
// result beat that reports the cursor, the sticky flags, the button levels and
// whether that byte completed a three-byte packet. A packet starts only on a byte
// with bit 3 set; other bytes in that slot are dropped but still answered. An
// item is held in an input register and its result is written to the output
// register, with the single state update step between those two registers; a
// new item can be accepted every cycle unless the output register is full and
// stalled. The limit registers are written on the configuration channel, which
// is always ready and should only be used while no item is in flight; a lowered
// limit takes effect at the next completed packet.
module ps2_mouse_packet_cursor
    import ps2mpc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_stall,
    input  item_t                     item_data,
    output logic                      result_valid,
    input  logic                      result_stall,
    output result_t                   result_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  coord_t                    cfg_data
);

    logic    pend_valid_reg;
    item_t   pend_item_reg;
    logic    result_valid_reg;
    result_t result_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t result_next;
    coord_t  limit_x_reg;
    coord_t  limit_y_reg;
    logic    advance;
    logic    accept;

    // The pending item moves on whenever the output register is free or drained.
    assign advance    = pend_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = pend_valid_reg && !advance;
    assign accept     = item_valid && !item_stall;
    assign cfg_ready  = 1'b1;

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    ps2mpc_step u_step (
        .cur     (state_reg),
        .item    (pend_item_reg),
        .limit_x (limit_x_reg),
        .limit_y (limit_y_reg),
        .nxt     (state_next),
        .res     (result_next)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_item_reg <= item_data;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    // Decoder state is committed as the item leaves the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{pos: POS_HEADER, header: '0, delta_x: '0, pos_x: '0,
                           pos_y: '0, moved: 1'b0, click: 1'b0, left: 1'b0,
                           right: 1'b0};
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Limit registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_x_reg <= LIMIT_X_RESET;
            limit_y_reg <= LIMIT_Y_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LIMIT_X: limit_x_reg <= cfg_data;
                CFG_LIMIT_Y: limit_y_reg <= cfg_data;
                default:     limit_x_reg <= limit_x_reg;
            endcase
        end
    end

endmodule

// ===== sv/ps2mpc_checker.sv =====
// Port-level checks for the PS/2 mouse packet cursor block, with its bind.
module ps2mpc_checker
    import ps2mpc_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      item_valid,
    input logic                      item_stall,
    input logic                      result_valid,
    input logic                      result_stall,
    input result_t                   result_data
);

    // A stalled result beat holds its value.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_data))
        else $error("result beat changed while stalled");

    // A new result beat is traced back to an item taken through the input register.
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && !item_stall, 2))
        else $error("result beat without a preceding item");

    // With the output register empty, the input side never stalls.
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !item_stall)
        else $error("item stalled while output is empty");

    // A packet-done beat is never stalled into a non-done one.
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall && result_data.packet_done
        |=> result_data.packet_done)
        else $error("packet-done beat lost under stall");

endmodule

bind ps2_mouse_packet_cursor ps2mpc_checker u_checker (.*);
